/* rtl/core/gda_pkg.sv */
package gda_pkg;

  typedef enum logic [1:0] {
    OP_VALIDATE = 2'd0,
    OP_ADD      = 2'd1,
    OP_SUB      = 2'd2,
    OP_COMPARE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ORD_EARLIER = 2'd0,
    ORD_EQUAL   = 2'd1,
    ORD_LATER   = 2'd2
  } order_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DEFAULT = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_DEF_MONTH = 2'd0;
  localparam logic [1:0] REG_DEF_DAY   = 2'd1;
  localparam logic [1:0] REG_DEF_YEAR  = 2'd2;

  localparam logic [3:0]  DEF_MONTH_RST = 4'd5;
  localparam logic [4:0]  DEF_DAY_RST   = 5'd11;
  localparam logic [13:0] DEF_YEAR_RST  = 14'd1959;

  // Fliegel-Van Flandern constants.
  localparam int unsigned JDN_EPOCH  = 32075;
  localparam int unsigned YEAR_BIAS  = 4800;
  localparam int unsigned CENT_BIAS  = 4900;
  localparam int unsigned DAYS_4Y    = 1461;
  localparam int unsigned DAYS_400Y  = 146097;
  localparam int unsigned JDN_SHIFT  = 68569;
  localparam int unsigned DOY_BIAS   = 31;
  localparam int unsigned CENT_BASE  = 4900;

  // Day numbers of 0001-01-01 and 9999-12-31, moved by JDN_SHIFT.
  localparam int unsigned JDN_FIRST  = 1721426;
  localparam int unsigned JDN_LAST   = 5373484;
  localparam logic signed [24:0] SHIFTED_FIRST = 25'(JDN_FIRST + JDN_SHIFT);
  localparam logic signed [24:0] SHIFTED_LAST  = 25'(JDN_LAST + JDN_SHIFT);

  localparam logic signed [24:0] DIFF_MAX = 25'sd4194303;
  localparam logic signed [24:0] DIFF_MIN = -25'sd4194304;

  // Reciprocals for the constant divisions. Each shift is chosen so that the
  // largest operand times the divisor stays below two to the shift, which
  // keeps the truncated product equal to the floor quotient.
  localparam int DIV100_SHIFT = 22;
  localparam logic [15:0] DIV100_RECIP =
    16'(((64'd1 << DIV100_SHIFT) + 64'd99) / 64'd100);

  localparam int CYC400_SHIFT = 43;
  localparam logic [25:0] CYC400_RECIP =
    26'(((64'd1 << CYC400_SHIFT) + 64'd146096) / 64'd146097);

  localparam int CYC4_SHIFT = 37;
  localparam logic [28:0] CYC4_RECIP =
    29'(((64'd4000 << CYC4_SHIFT) + 64'd1461000) / 64'd1461001);

  localparam int MON_SHIFT = 22;
  localparam logic [17:0] MON_RECIP =
    18'(((64'd80 << MON_SHIFT) + 64'd2446) / 64'd2447);

  typedef struct packed {
    op_t         op;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [13:0] year;
  } req_ctx_t;

  typedef struct packed {
    logic [24:0] p4y;
    logic [8:0]  q100;
  } jdn_part_t;

  typedef struct packed {
    logic [22:0] diff;
    order_t      order;
  } cmp_t;

  // Month term of the forward conversion, 367 * (m - 2 - 12a) / 12.
  function automatic logic [8:0] month_term(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd305;
      4'd1:    r = 9'd336;
      4'd2:    r = 9'd367;
      4'd3:    r = 9'd30;
      4'd4:    r = 9'd61;
      4'd5:    r = 9'd91;
      4'd6:    r = 9'd122;
      4'd7:    r = 9'd152;
      4'd8:    r = 9'd183;
      4'd9:    r = 9'd214;
      4'd10:   r = 9'd244;
      4'd11:   r = 9'd275;
      4'd12:   r = 9'd305;
      4'd13:   r = 9'd336;
      4'd14:   r = 9'd367;
      default: r = 9'd397;
    endcase
    return r;
  endfunction

  // Days before month index j in the March-based year, 2447 * j / 80.
  function automatic logic [8:0] month_start(input logic [3:0] j);
    logic [8:0] r;
    case (j)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd152;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd305;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd428;
      default: r = 9'd458;
    endcase
    return r;
  endfunction

  // First half of the forward conversion: the two year products.
  function automatic jdn_part_t jdn_front(input logic [3:0] m, input logic [13:0] y);
    logic        early;
    logic [14:0] yb;
    logic [14:0] yc;
    logic [30:0] qp;
    jdn_part_t   r;
    early  = (m <= 4'd2);
    yb     = 15'(y) + 15'(YEAR_BIAS) - 15'(early);
    yc     = 15'(y) + 15'(CENT_BIAS) - 15'(early);
    r.p4y  = 25'(yb) * 25'(DAYS_4Y);
    qp     = 31'(yc) * 31'(DIV100_RECIP);
    r.q100 = 9'(qp >> DIV100_SHIFT);
    return r;
  endfunction

  // Second half: sum of the terms. The result always lies in 0..2^23-1.
  function automatic logic [22:0] jdn_combine(input logic [4:0] d, input logic [3:0] m,
                                              input jdn_part_t p);
    logic [23:0] s;
    s = 24'(d) + 24'(p.p4y[24:2]) + 24'(month_term(m)) - 24'(JDN_EPOCH)
        - 24'((11'(p.q100) * 11'd3) >> 2);
    return s[22:0];
  endfunction

endpackage

/* rtl/core/gregorian_date_arithmetic.sv */
// Gregorian date arithmetic unit based on Julian Day Numbers.
// Requests enter on in_valid/in_ready with an op code and up to two dates and
// a signed day offset; results leave on res_valid/res_ready, one per request,
// in request order. Op 0 validates a date (invalid dates are replaced by the
// default date), ops 1 and 2 add or subtract the offset, op 3 gives the day
// difference and the order of the two dates.
// The datapath is a ten stage pipeline, and one request can be accepted every
// cycle unless every stage is full and res_ready is low. Each stage holds at
// most one request and moves forward when the stage after it is empty or
// moving, so bubbles are squeezed out.
// When res_ready is low the result is held and the stages behind it keep
// filling; in_ready drops only once every stage holds a request.
// The default date is written through cfg_we/cfg_index/cfg_data and should
// only change while no request is in flight. Synchronous reset empties the
// pipeline and restores the default date to May 11, 1959.
module gregorian_date_arithmetic (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [13:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  gda_pkg::op_t           op,
  input  logic [3:0]             in_month,
  input  logic [4:0]             in_day,
  input  logic [13:0]            in_year,
  input  logic signed [22:0]     offset_days,
  input  logic [3:0]             other_month,
  input  logic [4:0]             other_day,
  input  logic [13:0]            other_year,
  output logic                   res_valid,
  input  logic                   res_ready,
  output logic [3:0]             res_month,
  output logic [4:0]             res_day,
  output logic [13:0]            res_year,
  output logic signed [22:0]     day_difference,
  output gda_pkg::order_t        order,
  output gda_pkg::status_t       status
);
  import gda_pkg::*;

  localparam int STAGES = 10;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] adv;

  logic [3:0]  def_month;
  logic [4:0]  def_day;
  logic [13:0] def_year;

  req_ctx_t ctx [0:STAGES-2];
  cmp_t     cmp [2:STAGES-2];
  logic     rng [3:STAGES-2];

  // Stage 0
  jdn_part_t          part_a, part_b;
  jdn_part_t          part_a_s0, part_b_s0;
  logic signed [22:0] offs_s0;
  logic [3:0]         om_s0;
  logic [4:0]         od_s0;
  // Stage 1
  logic [22:0]        jd_a_s1, jd_b_s1;
  logic signed [22:0] offs_s1;
  // Stage 2
  logic signed [24:0] jd_ext, jd_sel, diff_full;
  cmp_t               cmp_next;
  logic signed [24:0] lsh_s2;
  // Stage 3
  logic [50:0]        n_prod;
  logic [7:0]         n_s3;
  logic [22:0]        lsh_s3;
  // Stage 4
  logic [25:0]        cyc_days, rem_full;
  logic [7:0]         n_s4;
  logic [15:0]        rem_s4;
  // Stage 5
  logic [45:0]        i_prod;
  logic [7:0]         n_s5, yc_s5;
  logic [15:0]        rem_s5;
  // Stage 6
  logic [19:0]        doy_full;
  logic [7:0]         n_s6, yc_s6;
  logic [9:0]         doy_s6;
  // Stage 7
  logic [27:0]        j_prod;
  logic [7:0]         n_s7, yc_s7;
  logic [9:0]         doy_s7;
  logic [3:0]         mj_s7;
  // Stage 8
  logic               late_year;
  logic [9:0]         cd_full;
  logic [15:0]        cy_full;
  logic [3:0]         cm_s8;
  logic [4:0]         cd_s8;
  logic [13:0]        cy_s8;
  // Stage 9
  logic [3:0]         mo_next;
  logic [4:0]         dy_next;
  logic [13:0]        yr_next;
  logic [22:0]        diff_next;
  order_t             ord_next;
  status_t            st_next;

  // ---------------------------------------------------------------------
  // Pipeline control
  // ---------------------------------------------------------------------
  always_comb begin
    adv[STAGES-1] = !vld[STAGES-1] || res_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_ready  = adv[0];
  assign res_valid = vld[STAGES-1];

  // ---------------------------------------------------------------------
  // Default date registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      def_month <= DEF_MONTH_RST;
      def_day   <= DEF_DAY_RST;
      def_year  <= DEF_YEAR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEF_MONTH: def_month <= cfg_data[3:0];
        REG_DEF_DAY:   def_day   <= cfg_data[4:0];
        REG_DEF_YEAR:  def_year  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request context travels along with the datapath.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ctx[0] <= '{op: op, month: in_month, day: in_day, year: in_year};
    end
    for (int k = 1; k <= STAGES - 2; k++) begin
      if (adv[k]) begin
        ctx[k] <= ctx[k-1];
      end
    end
    if (adv[2]) begin
      cmp[2] <= cmp_next;
    end
    for (int k = 3; k <= STAGES - 2; k++) begin
      if (adv[k]) begin
        cmp[k] <= cmp[k-1];
      end
    end
    if (adv[3]) begin
      rng[3] <= (lsh_s2 >= SHIFTED_FIRST) && (lsh_s2 <= SHIFTED_LAST);
    end
    for (int k = 4; k <= STAGES - 2; k++) begin
      if (adv[k]) begin
        rng[k] <= rng[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stages 0 and 1: date to day number for both dates
  // ---------------------------------------------------------------------
  assign part_a = jdn_front(in_month, in_year);
  assign part_b = jdn_front(other_month, other_year);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      part_a_s0 <= part_a;
      part_b_s0 <= part_b;
      offs_s0   <= offset_days;
      om_s0     <= other_month;
      od_s0     <= other_day;
    end
    if (adv[1]) begin
      jd_a_s1 <= jdn_combine(ctx[0].day, ctx[0].month, part_a_s0);
      jd_b_s1 <= jdn_combine(od_s0, om_s0, part_b_s0);
      offs_s1 <= offs_s0;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: apply the offset, form the difference for compare
  // ---------------------------------------------------------------------
  always_comb begin
    jd_ext = signed'({2'b00, jd_a_s1});
    case (ctx[1].op)
      OP_ADD:  jd_sel = jd_ext + 25'(offs_s1);
      OP_SUB:  jd_sel = jd_ext - 25'(offs_s1);
      default: jd_sel = jd_ext;
    endcase

    diff_full = jd_ext - signed'({2'b00, jd_b_s1});
    if (diff_full > DIFF_MAX) begin
      cmp_next.diff = DIFF_MAX[22:0];
    end else if (diff_full < DIFF_MIN) begin
      cmp_next.diff = DIFF_MIN[22:0];
    end else begin
      cmp_next.diff = diff_full[22:0];
    end
    if (diff_full < 0) begin
      cmp_next.order = ORD_EARLIER;
    end else if (diff_full == 0) begin
      cmp_next.order = ORD_EQUAL;
    end else begin
      cmp_next.order = ORD_LATER;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      lsh_s2 <= jd_sel + 25'(JDN_SHIFT);
    end
  end

  // ---------------------------------------------------------------------
  // Stages 3 to 8: day number back to a date
  // ---------------------------------------------------------------------
  // Outside the supported span the conversion result is not used, so the
  // datapath below only needs to be exact for day numbers inside it.
  assign n_prod = 51'({lsh_s2[22:0], 2'b00}) * 51'(CYC400_RECIP);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      n_s3   <= 8'(n_prod >> CYC400_SHIFT);
      lsh_s3 <= lsh_s2[22:0];
    end
  end

  assign cyc_days = 26'(n_s3) * 26'(DAYS_400Y) + 26'd3;
  assign rem_full = 26'(lsh_s3) - (cyc_days >> 2);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      n_s4   <= n_s3;
      rem_s4 <= rem_full[15:0];
    end
  end

  assign i_prod = 46'(17'(rem_s4) + 17'd1) * 46'(CYC4_RECIP);

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      n_s5   <= n_s4;
      rem_s5 <= rem_s4;
      yc_s5  <= 8'(i_prod >> CYC4_SHIFT);
    end
  end

  assign doy_full = 20'(rem_s5) - ((20'(yc_s5) * 20'(DAYS_4Y)) >> 2) + 20'(DOY_BIAS);

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      n_s6   <= n_s5;
      yc_s6  <= yc_s5;
      doy_s6 <= doy_full[9:0];
    end
  end

  assign j_prod = 28'(doy_s6) * 28'(MON_RECIP);

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      n_s7   <= n_s6;
      yc_s7  <= yc_s6;
      doy_s7 <= doy_s6;
      mj_s7  <= 4'(j_prod >> MON_SHIFT);
    end
  end

  // Month indexes 11 and up are January and February of the next year.
  assign late_year = (mj_s7 >= 4'd11);
  assign cd_full   = doy_s7 - 10'(month_start(mj_s7));
  assign cy_full   = 16'(n_s7) * 16'd100 + 16'(yc_s7) + 16'(late_year) - 16'(CENT_BASE);

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      cm_s8 <= mj_s7 + 4'd2 - (late_year ? 4'd12 : 4'd0);
      cd_s8 <= cd_full[4:0];
      cy_s8 <= cy_full[13:0];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 9: result selection and output register
  // ---------------------------------------------------------------------
  always_comb begin
    mo_next   = ctx[8].month;
    dy_next   = ctx[8].day;
    yr_next   = ctx[8].year;
    diff_next = '0;
    ord_next  = ORD_EARLIER;
    st_next   = ST_OK;
    unique case (ctx[8].op) inside
      OP_VALIDATE: begin
        // A date is valid when its day number is in range and the round trip returns it unchanged.
        if (!(rng[8] && cm_s8 == ctx[8].month && cd_s8 == ctx[8].day &&
              cy_s8 == ctx[8].year)) begin
          mo_next = def_month;
          dy_next = def_day;
          yr_next = def_year;
          st_next = ST_DEFAULT;
        end
      end
      OP_ADD, OP_SUB: begin
        if (rng[8]) begin
          mo_next = cm_s8;
          dy_next = cd_s8;
          yr_next = cy_s8;
        end else begin
          st_next = ST_RANGE;
        end
      end
      OP_COMPARE: begin
        diff_next = cmp[8].diff;
        ord_next  = cmp[8].order;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      res_month      <= mo_next;
      res_day        <= dy_next;
      res_year       <= yr_next;
      day_difference <= signed'(diff_next);
      order          <= ord_next;
      status         <= st_next;
    end
  end

endmodule

/* tb/gregorian_date_arithmetic_test.sv */
module gregorian_date_arithmetic_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gda_pkg::*;

  localparam longint YEAR_LO = 1;
  localparam longint YEAR_HI = 9999;
  localparam longint DIFF_CEIL = 4194303;
  localparam longint DIFF_FLOOR = -4194304;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int FLUSH_CYCLES = 20;
  localparam int MAX_REPORTS = 50;

  typedef struct {
    op_t                op;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [13:0]        year;
    logic signed [22:0] offset;
    logic [3:0]         other_month;
    logic [4:0]         other_day;
    logic [13:0]        other_year;
  } date_req_t;

  typedef struct {
    logic [3:0]         month;
    logic [4:0]         day;
    logic [13:0]        year;
    logic signed [22:0] diff;
    order_t             ord;
    status_t            st;
  } date_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = REG_DEF_MONTH;
  logic [13:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  op_t                op = OP_VALIDATE;
  logic [3:0]         in_month = '0;
  logic [4:0]         in_day = '0;
  logic [13:0]        in_year = '0;
  logic signed [22:0] offset_days = '0;
  logic [3:0]         other_month = 4'd1;
  logic [4:0]         other_day = 5'd1;
  logic [13:0]        other_year = 14'd1;
  logic               res_valid;
  logic               res_ready = 1'b0;
  logic [3:0]         res_month;
  logic [4:0]         res_day;
  logic [13:0]        res_year;
  logic signed [22:0] day_difference;
  order_t             order;
  status_t            status;

  // Local copy of the default date registers.
  logic [3:0]  def_month = DEF_MONTH_RST;
  logic [4:0]  def_day = DEF_DAY_RST;
  logic [13:0] def_year = DEF_YEAR_RST;

  date_req_t    pending_requests[$];
  date_result_t expected_results[$];
  date_req_t    cur_req;

  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int mismatch_count = 0;
  int checked_count = 0;
  int accepted_count = 0;
  int settings_count = 0;
  int op_count[4] = '{default: 0};
  int status_count[3] = '{default: 0};

  gregorian_date_arithmetic dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .in_month(in_month), .in_day(in_day), .in_year(in_year),
    .offset_days(offset_days),
    .other_month(other_month), .other_day(other_day), .other_year(other_year),
    .res_valid(res_valid), .res_ready(res_ready),
    .res_month(res_month), .res_day(res_day), .res_year(res_year),
    .day_difference(day_difference), .order(order), .status(status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Gregorian date to Julian Day Number; all divisions truncate toward zero.
  function automatic longint date_to_day_number(input longint m, input longint d,
                                                input longint y);
    longint a;
    a = (m - 14) / 12;
    return d - 32075 + 1461 * (y + 4800 + a) / 4 + 367 * (m - 2 - a * 12) / 12
           - 3 * ((y + 4900 + a) / 100) / 4;
  endfunction

  function automatic void day_number_to_date(input longint jd, output longint m,
                                             output longint d, output longint y);
    longint l, n, i, j, k;
    l = jd + 68569;
    n = 4 * l / 146097;
    l = l - (146097 * n + 3) / 4;
    i = 4000 * (l + 1) / 1461001;
    l = l - 1461 * i / 4 + 31;
    j = 80 * l / 2447;
    k = l - 2447 * j / 80;
    l = j / 11;
    j = j + 2 - 12 * l;
    y = 100 * (n - 49) + i + l;
    m = j;
    d = k;
  endfunction

  function automatic date_result_t predict_date_result(input date_req_t r);
    longint m, d, y, jd, cm, cd, cy, full;
    date_result_t res;
    m = r.month;
    d = r.day;
    y = r.year;
    res.month = r.month;
    res.day = r.day;
    res.year = r.year;
    res.diff = '0;
    res.ord = ORD_EARLIER;
    res.st = ST_OK;
    case (r.op)
      OP_VALIDATE: begin
        day_number_to_date(date_to_day_number(m, d, y), cm, cd, cy);
        if (cm != m || cd != d || cy != y || y < YEAR_LO || y > YEAR_HI) begin
          res.month = def_month;
          res.day = def_day;
          res.year = def_year;
          res.st = ST_DEFAULT;
        end
      end
      OP_ADD, OP_SUB: begin
        jd = date_to_day_number(m, d, y);
        if (r.op == OP_ADD) jd = jd + longint'(r.offset);
        else jd = jd - longint'(r.offset);
        day_number_to_date(jd, cm, cd, cy);
        if (cy < YEAR_LO || cy > YEAR_HI || cm < 1 || cm > 12 || cd < 1 || cd > 31) begin
          res.st = ST_RANGE;
        end else begin
          res.month = 4'(cm);
          res.day = 5'(cd);
          res.year = 14'(cy);
        end
      end
      default: begin
        full = date_to_day_number(m, d, y)
               - date_to_day_number(r.other_month, r.other_day, r.other_year);
        res.ord = (full < 0) ? ORD_EARLIER : ((full == 0) ? ORD_EQUAL : ORD_LATER);
        if (full > DIFF_CEIL) full = DIFF_CEIL;
        if (full < DIFF_FLOOR) full = DIFF_FLOOR;
        res.diff = 23'(full);
      end
    endcase
    return res;
  endfunction

  function automatic date_req_t make_request(input op_t o, input int m, input int d,
                                             input int y, input int off, input int om,
                                             input int od, input int oy);
    date_req_t r;
    r.op = o;
    r.month = 4'(m);
    r.day = 5'(d);
    r.year = 14'(y);
    r.offset = 23'(off);
    r.other_month = 4'(om);
    r.other_day = 5'(od);
    r.other_year = 14'(oy);
    return r;
  endfunction

  // Real calendar date, with extra weight on the first and last years.
  function automatic void pick_valid_date(output logic [3:0] m, output logic [4:0] d,
                                          output logic [13:0] y);
    int yy, mm, len, pick;
    pick = $urandom_range(9, 0);
    yy = (pick == 0) ? 1 : ((pick == 1) ? 9999 : $urandom_range(9999, 1));
    mm = $urandom_range(12, 1);
    case (mm)
      2: len = (((yy % 4 == 0) && (yy % 100 != 0)) || (yy % 400 == 0)) ? 29 : 28;
      4, 6, 9, 11: len = 30;
      default: len = 31;
    endcase
    m = 4'(mm);
    d = 5'($urandom_range(len, 1));
    y = 14'(yy);
  endfunction

  function automatic date_req_t random_request();
    date_req_t r;
    int pick, v;
    bit real_date;
    r.op = op_t'($urandom_range(3, 0));
    real_date = ($urandom_range(99, 0) < 75);
    if (real_date) begin
      pick_valid_date(r.month, r.day, r.year);
    end else begin
      r.month = 4'($urandom_range(15, 0));
      r.day = 5'($urandom_range(31, 0));
      r.year = 14'($urandom_range(9999, 0));
    end
    pick = $urandom_range(99, 0);
    if (pick < 50) begin
      v = $urandom_range(800, 0);
      v = v - 400;
    end else if (pick < 80) begin
      v = $urandom_range(7400000, 0);
      v = v - 3700000;
    end else begin
      v = $urandom();
    end
    r.offset = 23'(v);
    pick = $urandom_range(99, 0);
    if (pick < 15 && real_date) begin
      r.other_month = r.month;
      r.other_day = r.day;
      r.other_year = r.year;
    end else if (pick < 80) begin
      pick_valid_date(r.other_month, r.other_day, r.other_year);
    end else begin
      r.other_month = 4'($urandom_range(12, 1));
      r.other_day = 5'($urandom_range(31, 1));
      r.other_year = 14'($urandom_range(9999, 1));
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) $display("MISMATCH: %s", msg);
    mismatch_count++;
  endtask

  task automatic write_default(input logic [1:0] idx, input logic [13:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_DEF_MONTH: def_month = data[3:0];
      REG_DEF_DAY:   def_day = data[4:0];
      default:       def_year = data;
    endcase
  endtask

  task automatic set_defaults(input logic [13:0] m, input logic [13:0] d,
                              input logic [13:0] y);
    write_default(REG_DEF_MONTH, m);
    write_default(REG_DEF_DAY, d);
    write_default(REG_DEF_YEAR, y);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  task automatic set_idle(input int sender_pct, input int receiver_pct);
    @(negedge clk);
    sender_idle_pct = sender_pct;
    receiver_idle_pct = receiver_pct;
  endtask

  task automatic queue_random(input int n);
    @(negedge clk);
    repeat (n) pending_requests.push_back(random_request());
  endtask

  // Returns once every request has been sent and answered.
  task automatic drain();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  always @(posedge clk) begin : drive_requests
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_date_result(cur_req));
        accepted_count++;
        op_count[cur_req.op]++;
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
          cur_req = pending_requests.pop_front();
          op <= cur_req.op;
          in_month <= cur_req.month;
          in_day <= cur_req.day;
          in_year <= cur_req.year;
          offset_days <= cur_req.offset;
          other_month <= cur_req.other_month;
          other_day <= cur_req.other_day;
          other_year <= cur_req.other_year;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    date_result_t want;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        checked_count++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                    checked_count));
        end else begin
          want = expected_results.pop_front();
          status_count[want.st]++;
          if (res_month !== want.month)
            report_mismatch($sformatf("result %0d res_month: got %0d, expected %0d",
                                      checked_count, res_month, want.month));
          if (res_day !== want.day)
            report_mismatch($sformatf("result %0d res_day: got %0d, expected %0d",
                                      checked_count, res_day, want.day));
          if (res_year !== want.year)
            report_mismatch($sformatf("result %0d res_year: got %0d, expected %0d",
                                      checked_count, res_year, want.year));
          if (day_difference !== want.diff)
            report_mismatch($sformatf("result %0d day_difference: got %0d, expected %0d",
                                      checked_count, day_difference, want.diff));
          if (order !== want.ord)
            report_mismatch($sformatf("result %0d order: got %0d, expected %0d",
                                      checked_count, order, want.ord));
          if (status !== want.st)
            report_mismatch($sformatf("result %0d status: got %0d, expected %0d",
                                      checked_count, status, want.st));
        end
      end
      res_ready <= ($urandom_range(99, 0) >= receiver_idle_pct);
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (res_valid && res_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
    $display("gregorian_date_arithmetic verification failed");
    $finish;
  end

  initial begin : run_test
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed requests under the reset default date.
    set_idle(33, 61);
    @(negedge clk);
    pending_requests.push_back(make_request(OP_VALIDATE, 1, 1, 1, 0, 1, 1, 1));
    pending_requests.push_back(make_request(OP_VALIDATE, 12, 31, 9999, 0, 1, 1, 1));
    pending_requests.push_back(make_request(OP_VALIDATE, 2, 29, 2000, 0, 1, 1, 1));
    pending_requests.push_back(make_request(OP_VALIDATE, 2, 29, 1900, 0, 1, 1, 1));
    pending_requests.push_back(make_request(OP_VALIDATE, 2, 29, 2024, 0, 1, 1, 1));
    pending_requests.push_back(make_request(OP_VALIDATE, 4, 31, 2021, 0, 1, 1, 1));
    pending_requests.push_back(make_request(OP_VALIDATE, 13, 1, 2020, 0, 1, 1, 1));
    pending_requests.push_back(make_request(OP_VALIDATE, 0, 0, 0, 0, 1, 1, 1));
    // Year zero survives the round trip but is still out of range.
    pending_requests.push_back(make_request(OP_VALIDATE, 1, 1, 0, 0, 1, 1, 1));
    pending_requests.push_back(make_request(OP_VALIDATE, 15, 31, 9999, 0, 1, 1, 1));
    pending_requests.push_back(make_request(OP_ADD, 12, 31, 9999, 1, 1, 1, 1));
    pending_requests.push_back(make_request(OP_ADD, 1, 1, 1, -1, 1, 1, 1));
    pending_requests.push_back(make_request(OP_ADD, 2, 28, 2000, 1, 1, 1, 1));
    pending_requests.push_back(make_request(OP_ADD, 1, 1, 1, 4194303, 12, 31, 9999));
    pending_requests.push_back(make_request(OP_ADD, 12, 31, 9999, -4194304, 1, 1, 1));
    pending_requests.push_back(make_request(OP_SUB, 3, 1, 2000, 1, 1, 1, 1));
    pending_requests.push_back(make_request(OP_SUB, 1, 1, 1, -4194304, 1, 1, 1));
    pending_requests.push_back(make_request(OP_SUB, 12, 31, 9999, 4194303, 1, 1, 1));
    pending_requests.push_back(make_request(OP_SUB, 0, 0, 0, 0, 1, 1, 1));
    pending_requests.push_back(make_request(OP_SUB, 14, 31, 5000, 1000, 1, 1, 1));
    pending_requests.push_back(make_request(OP_COMPARE, 6, 15, 2020, 0, 6, 15, 2020));
    pending_requests.push_back(make_request(OP_COMPARE, 1, 1, 1, 0, 12, 31, 9999));
    pending_requests.push_back(make_request(OP_COMPARE, 12, 31, 9999, 0, 1, 1, 1));
    pending_requests.push_back(make_request(OP_COMPARE, 15, 31, 9999, 0, 1, 1, 1));
    // An impossible date lands on the same day number as the next real one.
    pending_requests.push_back(make_request(OP_COMPARE, 2, 29, 2023, 0, 3, 1, 2023));
    drain();

    // Smallest default date; the sender waits for every result halfway through.
    set_defaults(14'd1, 14'd1, 14'd1);
    queue_random(175);
    drain();
    queue_random(175);
    drain();

    // Largest values the registers hold, beyond the calendar range.
    set_idle(61, 33);
    set_defaults(14'd15, 14'd31, 14'd16383);
    queue_random(350);
    drain();

    set_idle(0, 0);
    set_defaults(14'd12, 14'd0, 14'd9999);
    queue_random(200);
    drain();

    // Random register data, including bits above each register's width.
    repeat (2) begin
      set_defaults(14'($urandom()), 14'($urandom()), 14'($urandom()));
      queue_random(100);
      drain();
    end

    repeat (FLUSH_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    $display("Sent %0d requests (validate %0d, add %0d, subtract %0d, compare %0d) under %0d default dates.",
             accepted_count, op_count[OP_VALIDATE], op_count[OP_ADD], op_count[OP_SUB],
             op_count[OP_COMPARE], settings_count + 1);
    $display("Checked %0d results: %0d ok, %0d replaced by default, %0d out of range; %0d mismatches.",
             checked_count, status_count[ST_OK], status_count[ST_DEFAULT],
             status_count[ST_RANGE], mismatch_count);
    if (mismatch_count == 0) begin
      $display("gregorian_date_arithmetic verification clean");
    end else begin
      $display("gregorian_date_arithmetic verification failed");
    end
    $finish;
  end

endmodule
